FILE: hdl/bounded_deque_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque unit.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_UNIT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define BDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define BDQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, command and status codes and the cell control bundle
// of the bounded deque unit.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Default sizes.
    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    // Width of the command and status fields.
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // Command codes; code 7 is unused and acts as a no-op.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_HEAD = 3'd0,
        CMD_PUSH_TAIL = 3'd1,
        CMD_POP_HEAD  = 3'd2,
        CMD_POP_TAIL  = 3'd3,
        CMD_PEEK_HEAD = 3'd4,
        CMD_PEEK_TAIL = 3'd5,
        CMD_CLEAR     = 3'd6
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Control bundle broadcast to every cell; at most one bit is set.
    typedef struct packed {
        logic clear;
        logic push_head;
        logic push_tail;
        logic pop_head;
        logic pop_tail;
    } cell_ctrl_t;

endpackage

FILE: hdl/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One position of the deque. Cell 0 holds the head entry; entries shift
// toward higher cells on a head push and toward cell 0 on a head pop.
// ----------------------------------------------------------------------------
module bdq_cell #(
    parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bdq_pkg::cell_ctrl_t    ctrl,
    input  logic [WORD_BITS-1:0]   word,
    input  logic                   left_valid,
    input  logic [WORD_BITS-1:0]   left_data,
    input  logic                   right_valid,
    input  logic [WORD_BITS-1:0]   right_data,
    output logic                   valid,
    output logic [WORD_BITS-1:0]   data,
    output logic                   tail
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;

    // Next contents of this position for the current command.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.push_head)
        begin
            valid_next = left_valid;
            data_next  = left_data;
        end
        else if (ctrl.push_tail)
        begin
            // The first free position takes the new word.
            if (!valid_reg && left_valid)
            begin
                valid_next = 1'b1;
                data_next  = word;
            end
        end
        else if (ctrl.pop_head)
        begin
            valid_next = right_valid;
            data_next  = right_data;
        end
        else if (ctrl.pop_tail)
        begin
            if (valid_reg && !right_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Occupancy flag of this position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stored word.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign tail  = valid_reg & ~right_valid;

endmodule

FILE: hdl/bounded_deque_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_unit
// Bounded double-ended queue built as a row of shifting cells, with a
// registered result for every accepted request.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_stall  | cmd, data_in
//   out     | out_valid / out_stall| data_out, status, fill_count,
//           |                      | is_empty, is_full
//
// A request is executed in the cycle it is accepted; its result appears in
// the output register in the next cycle, so one request per cycle is taken
// while in_stall is low. The rate is set by the single output register:
// in_stall is high only while a result is held and out_stall is high.
// Reset empties the queue at once; stored words themselves are not cleared.
// ----------------------------------------------------------------------------
`include "bounded_deque_unit_macros.svh"

module bounded_deque_unit #(
    parameter int CAPACITY  = bdq_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEF,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bdq_pkg::CMD_W-1:0]     cmd,
    input  logic [WORD_BITS-1:0]          data_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [WORD_BITS-1:0]          data_out,
    output logic [bdq_pkg::STATUS_W-1:0]  status,
    output logic [CNT_W-1:0]              fill_count,
    output logic                          is_empty,
    output logic                          is_full
);

    logic                 accept;
    logic                 full;
    logic                 empty;
    bdq_pkg::cell_ctrl_t  ctrl;
    bdq_pkg::status_t     status_res;
    logic [WORD_BITS-1:0] data_res;
    logic [WORD_BITS-1:0] tail_word;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic [CAPACITY-1:0]  cell_valid;
    logic [CAPACITY-1:0]  cell_tail;
    logic [WORD_BITS-1:0] cell_data [CAPACITY];

    logic                     out_valid_reg;
    logic [WORD_BITS-1:0]     data_out_reg;
    bdq_pkg::status_t         status_reg;
    logic [CNT_W-1:0]         fill_count_reg;
    logic                     is_empty_reg;
    logic                     is_full_reg;

    assign accept   = in_valid & ~in_stall;
    assign in_stall = out_valid_reg & out_stall;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    // Decode the request into cell controls, status and result word.
    always_comb
    begin
        ctrl       = '0;
        status_res = bdq_pkg::ST_OK;
        data_res   = '0;
        count_next = count_reg;
        unique case (bdq_pkg::cmd_t'(cmd))
            bdq_pkg::CMD_PUSH_HEAD,
            bdq_pkg::CMD_PUSH_TAIL:
            begin
                if (full)
                begin
                    status_res = bdq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.push_head = (bdq_pkg::cmd_t'(cmd) == bdq_pkg::CMD_PUSH_HEAD);
                    ctrl.push_tail = (bdq_pkg::cmd_t'(cmd) == bdq_pkg::CMD_PUSH_TAIL);
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            bdq_pkg::CMD_POP_HEAD,
            bdq_pkg::CMD_PEEK_HEAD:
            begin
                if (empty)
                begin
                    status_res = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    data_res = cell_data[0];
                    if (bdq_pkg::cmd_t'(cmd) == bdq_pkg::CMD_POP_HEAD)
                    begin
                        ctrl.pop_head = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
            end
            bdq_pkg::CMD_POP_TAIL,
            bdq_pkg::CMD_PEEK_TAIL:
            begin
                if (empty)
                begin
                    status_res = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    data_res = tail_word;
                    if (bdq_pkg::cmd_t'(cmd) == bdq_pkg::CMD_POP_TAIL)
                    begin
                        ctrl.pop_tail = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
            end
            bdq_pkg::CMD_CLEAR:
            begin
                ctrl.clear = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
        if (!accept)
        begin
            ctrl       = '0;
            count_next = count_reg;
        end
    end

    // Row of cells; cell 0 sees the incoming word as its left neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                 lv;
        logic [WORD_BITS-1:0] ld;
        logic                 rv;
        logic [WORD_BITS-1:0] rd;

        if (i == 0)
        begin : g_first
            assign lv = 1'b1;
            assign ld = data_in;
        end
        else
        begin : g_mid_left
            assign lv = cell_valid[i-1];
            assign ld = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rv = 1'b0;
            assign rd = '0;
        end
        else
        begin : g_mid_right
            assign rv = cell_valid[i+1];
            assign rd = cell_data[i+1];
        end

        bdq_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .word        (data_in),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .valid       (cell_valid[i]),
            .data        (cell_data[i]),
            .tail        (cell_tail[i])
        );
    end

    // The single cell flagged as tail drives the tail word.
    always_comb
    begin
        tail_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_word = tail_word | (cell_data[i] & {WORD_BITS{cell_tail[i]}});
        end
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg   <= data_res;
            status_reg     <= status_res;
            fill_count_reg <= count_next;
            is_empty_reg   <= (count_next == '0);
            is_full_reg    <= (count_next == CNT_W'(CAPACITY));
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = data_out_reg;
    assign status     = status_reg;
    assign fill_count = fill_count_reg;
    assign is_empty   = is_empty_reg;
    assign is_full    = is_full_reg;

    // Checks on the cell row and the count.
    `BDQ_ASSERT_ALWAYS(a_count_bound, !rst_n || count_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `BDQ_ASSERT(a_valid_matches_count, $countones(cell_valid) == 32'(count_reg), "cell valid bits disagree with fill count")
    `BDQ_ASSERT(a_single_tail, $onehot0(cell_tail), "more than one tail cell")
    `BDQ_ASSERT(a_full_push_holds, accept && full && (cmd == bdq_pkg::CMD_PUSH_HEAD || cmd == bdq_pkg::CMD_PUSH_TAIL) |=> $stable(count_reg) && status_reg == bdq_pkg::ST_FULL, "refused push changed the queue")

endmodule
